### rtl/knn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types, sizes and helpers of the k-nearest-neighbor classifier.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int NUM_CLASSES   = 16;

    localparam int CLASS_W = 4;
    localparam int DIST_W  = 31;
    localparam int CFG_W   = 5;
    localparam int IDX_W   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);

    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

    typedef struct packed {
        logic [CLASS_W-1:0] class_label;
        logic [DIST_W-1:0]  distance_value;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_W-1:0] winning_class;
        logic [4:0]         winning_votes;
        logic [4:0]         neighbors_used;
    } t_out_item;

    // Classes of the kept list, nearest first, and the clipped k.
    typedef struct packed {
        logic [MAX_NEIGHBORS-1:0][CLASS_W-1:0] cls;
        logic [CNT_W-1:0]                      k;
    } t_vote_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [CLASS_W-1:0] sat_label(input logic [CLASS_W-1:0] label);
        logic [CLASS_W-1:0] res;
        res = label;
        if (int'(label) >= NUM_CLASSES) begin
            res = CLASS_W'(NUM_CLASSES - 1);
        end
        return res;
    endfunction

    // k from the register: zero counts as one, large values saturate.
    function automatic logic [CNT_W-1:0] clip_k(input logic [CFG_W-1:0] n);
        logic [CNT_W-1:0] res;
        if (n == '0) begin
            res = CNT_W'(1);
        end else if (int'(n) > MAX_NEIGHBORS) begin
            res = CNT_W'(MAX_NEIGHBORS);
        end else begin
            res = CNT_W'(n);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/knn_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_insert
// Front end: sorted list of the nearest points, one insertion per beat.
// Every slot compares in parallel; on the last point a vote job is issued.
// ----------------------------------------------------------------------------
module knn_insert (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire knn_pkg::t_in_item         i_item,
    input  wire logic [knn_pkg::CFG_W-1:0] i_neighbor_count,
    output logic                           o_job_push,
    output knn_pkg::t_vote_job             o_job
);

    localparam int N = knn_pkg::MAX_NEIGHBORS;

    logic [knn_pkg::DIST_W-1:0]  r_dist [N];
    logic [knn_pkg::CLASS_W-1:0] r_cls  [N];
    logic [knn_pkg::CNT_W-1:0]   r_fill;

    logic [knn_pkg::DIST_W-1:0]  n_dist [N];
    logic [knn_pkg::CLASS_W-1:0] n_cls  [N];
    logic [knn_pkg::CNT_W-1:0]   n_fill;

    logic [N-1:0]                place;
    logic [knn_pkg::CLASS_W-1:0] new_cls;
    logic [knn_pkg::CNT_W-1:0]   fill_inc;
    logic [knn_pkg::CNT_W-1:0]   k_cfg;

    assign new_cls = knn_pkg::sat_label(i_item.class_label);

    // Empty slots act as an infinite distance, so place[] is a thermometer.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            place[i] = (knn_pkg::CNT_W'(i) >= r_fill) || (r_dist[i] > i_item.distance_value);
        end
        for (int i = 0; i < N; i++) begin
            n_dist[i] = r_dist[i];
            n_cls[i]  = r_cls[i];
        end
        if (place[0]) begin
            n_dist[0] = i_item.distance_value;
            n_cls[0]  = new_cls;
        end
        for (int i = 1; i < N; i++) begin
            if (place[i]) begin
                if (!place[i-1]) begin
                    n_dist[i] = i_item.distance_value;
                    n_cls[i]  = new_cls;
                end else begin
                    n_dist[i] = r_dist[i-1];
                    n_cls[i]  = r_cls[i-1];
                end
            end
        end
    end

    assign fill_inc = (r_fill < knn_pkg::CNT_W'(N)) ? r_fill + 1'b1 : r_fill;
    assign n_fill   = i_item.last_point ? '0 : fill_inc;
    assign k_cfg    = knn_pkg::clip_k(i_neighbor_count);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            o_job.cls[i] = n_cls[i];
        end
        o_job.k = (k_cfg < fill_inc) ? k_cfg : fill_inc;
    end

    assign o_job_push = i_accept && i_item.last_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < N; i++) begin
                r_dist[i] <= n_dist[i];
                r_cls[i]  <= n_cls[i];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/knn_job_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_job_fifo
// Short register queue of vote jobs between the front and back ends.
// ----------------------------------------------------------------------------
module knn_job_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire knn_pkg::t_vote_job i_job,
    input  wire logic               i_pop,
    output knn_pkg::t_vote_job      o_job,
    output knn_pkg::t_queue_status  o_status
);

    localparam int D = knn_pkg::JOB_DEPTH;

    knn_pkg::t_vote_job              r_mem [D];
    logic [knn_pkg::JOB_PTR_W-1:0]   r_wr_ptr;
    logic [knn_pkg::JOB_PTR_W-1:0]   r_rd_ptr;
    logic [knn_pkg::JOB_PTR_W:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == (knn_pkg::JOB_PTR_W+1)'(D));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

### rtl/knn_vote.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_vote
// Back end: tallies one neighbor per cycle and tracks the leading class,
// then parks the result in the output register.
// ----------------------------------------------------------------------------
module knn_vote (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire knn_pkg::t_vote_job    i_job,
    input  wire knn_pkg::t_queue_status i_job_status,
    output logic                       o_job_pop,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output knn_pkg::t_out_item         o_result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]                  r_state;
    knn_pkg::t_vote_job          r_job;
    logic [knn_pkg::CNT_W-1:0]   r_idx;
    logic [knn_pkg::CNT_W-1:0]   r_votes [knn_pkg::NUM_CLASSES];
    logic [knn_pkg::CLASS_W-1:0] r_best_class;
    logic [knn_pkg::CNT_W-1:0]   r_best_votes;
    logic                        r_out_valid;
    knn_pkg::t_out_item          r_out;

    logic [knn_pkg::CLASS_W-1:0] cur_cls;
    logic [knn_pkg::CNT_W-1:0]   cur_votes;
    logic                        take_lead;
    logic                        out_free;

    assign cur_cls   = r_job.cls[r_idx[knn_pkg::IDX_W-1:0]];
    assign cur_votes = r_votes[cur_cls] + 1'b1;
    // Counts only grow, so a lower class reaching the lead value takes over.
    assign take_lead = (cur_votes > r_best_votes) ||
                       ((cur_votes == r_best_votes) && (cur_cls < r_best_class));
    assign out_free  = !r_out_valid || i_pop;
    assign o_job_pop = (r_state == ST_IDLE) && !i_job_status.empty;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_status.empty) begin
                        r_state <= ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    if (r_idx + 1'b1 == r_job.k) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_job        <= i_job;
            r_idx        <= '0;
            r_best_class <= '0;
            r_best_votes <= '0;
            for (int i = 0; i < knn_pkg::NUM_CLASSES; i++) begin
                r_votes[i] <= '0;
            end
        end else if (r_state == ST_COUNT) begin
            r_idx            <= r_idx + 1'b1;
            r_votes[cur_cls] <= cur_votes;
            if (take_lead) begin
                r_best_class <= cur_cls;
                r_best_votes <= cur_votes;
            end
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out.winning_class  <= r_best_class;
            r_out.winning_votes  <= 5'(r_best_votes);
            r_out.neighbors_used <= 5'(r_job.k);
        end
    end

endmodule
`default_nettype wire

### rtl/knn_majority_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_majority_classifier
// k-nearest-neighbor majority vote over a stream of labelled distances.
// ----------------------------------------------------------------------------
// Throughput: one training point per cycle; full stalls only while two vote
//   jobs wait, since the back end counts one query at a time.
// Result path: job queue, back end count and done states, output register.
// Reset: clears the fill count, job queue and result valid flag, sets k to 1;
//   the kept neighbor slots are not cleared.
module knn_majority_classifier (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire knn_pkg::t_in_item         i_item,
    input  wire logic                      pop,
    output logic                           empty,
    output knn_pkg::t_out_item             o_result,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [knn_pkg::CFG_W-1:0] i_cfg_data
);

    logic [knn_pkg::CFG_W-1:0] r_neighbor_count;
    logic                      accept;
    logic                      job_push;
    logic                      job_pop;
    knn_pkg::t_vote_job        job_in;
    knn_pkg::t_vote_job        job_out;
    knn_pkg::t_queue_status    job_status;

    assign o_cfg_ready = 1'b1;
    assign full        = job_status.full;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_count <= knn_pkg::CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_neighbor_count <= i_cfg_data;
        end
    end

    knn_insert u_insert (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_item          (i_item),
        .i_neighbor_count(r_neighbor_count),
        .o_job_push      (job_push),
        .o_job           (job_in)
    );

    knn_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_status(job_status)
    );

    knn_vote u_vote (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_status(job_status),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

### rtl/knn_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_chk
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module knn_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               pop,
    input wire logic               empty,
    input wire knn_pkg::t_out_item o_result
);

    // Result beat waits unchanged until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result changed or vanished while waiting");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.neighbors_used != 5'd0) &&
                   (o_result.neighbors_used <= 5'(knn_pkg::MAX_NEIGHBORS)))
        else $error("neighbors_used out of range");

    a_votes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.winning_votes != 5'd0) &&
                   (o_result.winning_votes <= o_result.neighbors_used))
        else $error("winning_votes inconsistent with neighbors_used");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule

bind knn_majority_classifier knn_chk u_knn_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .pop     (pop),
    .empty   (empty),
    .o_result(o_result)
);
`default_nettype wire

### tb/sv/knn_majority_classifier_tb.sv
// ----------------------------------------------------------------------------
// knn_majority_classifier_tb
// Streams labelled distances into the k-nearest-neighbor classifier, keeps a
// sorted neighbor list of its own to predict each vote, and checks every
// result beat field by field. Directed queries cover the k clipping rules,
// ties and a full list; random queries follow under several k settings with
// random gaps on both queue sides.
// ----------------------------------------------------------------------------
module knn_majority_classifier_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 24;    // longest vote of the back end plus margin
    localparam int PHASE_POINTS   = 140;

    localparam int DIST_NARROW = 0;
    localparam int DIST_MID    = 1;
    localparam int DIST_WIDE   = 2;

    localparam logic [knn_pkg::DIST_W-1:0] DIST_ALL_ONES = '1;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        push;
    logic                        full;
    knn_pkg::t_in_item           i_item;
    logic                        pop;
    logic                        empty;
    knn_pkg::t_out_item          o_result;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [knn_pkg::CFG_W-1:0]   i_cfg_data;

    // shadow of the classifier
    logic [knn_pkg::DIST_W-1:0]  near_dist [knn_pkg::MAX_NEIGHBORS];
    logic [knn_pkg::CLASS_W-1:0] near_cls  [knn_pkg::MAX_NEIGHBORS];
    int                          near_fill;
    logic [knn_pkg::CFG_W-1:0]   k_setting;
    knn_pkg::t_out_item          vote_q[$];

    int errors;
    int points_sent;
    int queries_sent;
    int results_seen;
    int cfg_writes;
    int stall_cycles;
    int pop_hold;
    bit burst;

    knn_majority_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [knn_pkg::DIST_W-1:0] pick_distance(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return '0;
        end else if (r < 8) begin
            return DIST_ALL_ONES;
        end
        case (mode)
            DIST_NARROW: return knn_pkg::DIST_W'($urandom_range(0, 15));
            DIST_MID:    return knn_pkg::DIST_W'($urandom_range(0, 4095));
            default:     return knn_pkg::DIST_W'($urandom);
        endcase
    endfunction

    // Sorted insert of one point; on the last point, vote and clear.
    function automatic void track_point(input knn_pkg::t_in_item it);
        int pos;
        int i;
        int k;
        int best;
        int votes [knn_pkg::NUM_CLASSES];
        logic [knn_pkg::CLASS_W-1:0] cls;
        knn_pkg::t_out_item res;
        cls = it.class_label;
        if (int'(cls) >= knn_pkg::NUM_CLASSES) begin
            cls = knn_pkg::CLASS_W'(knn_pkg::NUM_CLASSES - 1);
        end
        pos = near_fill;
        while (pos > 0 && near_dist[pos-1] > it.distance_value) begin
            pos--;
        end
        if (pos < knn_pkg::MAX_NEIGHBORS) begin
            i = (near_fill < knn_pkg::MAX_NEIGHBORS) ? near_fill
                                                      : knn_pkg::MAX_NEIGHBORS - 1;
            while (i > pos) begin
                near_dist[i] = near_dist[i-1];
                near_cls[i]  = near_cls[i-1];
                i--;
            end
            near_dist[pos] = it.distance_value;
            near_cls[pos]  = cls;
            if (near_fill < knn_pkg::MAX_NEIGHBORS) begin
                near_fill++;
            end
        end
        if (it.last_point) begin
            k = int'(k_setting);
            if (k == 0) k = 1;
            if (k > knn_pkg::MAX_NEIGHBORS) k = knn_pkg::MAX_NEIGHBORS;
            if (k > near_fill) k = near_fill;
            foreach (votes[j]) votes[j] = 0;
            for (i = 0; i < k; i++) begin
                votes[near_cls[i]]++;
            end
            best = 0;
            for (i = 1; i < knn_pkg::NUM_CLASSES; i++) begin
                if (votes[i] > votes[best]) begin
                    best = i;
                end
            end
            res.winning_class  = knn_pkg::CLASS_W'(best);
            res.winning_votes  = 5'(votes[best]);
            res.neighbors_used = 5'(k);
            vote_q = {vote_q, res};
            near_fill = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        errors++;
        $display("ERROR @%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    task automatic send_point(input logic [knn_pkg::CLASS_W-1:0] cls,
                              input logic [knn_pkg::DIST_W-1:0] dist_val,
                              input logic last);
        knn_pkg::t_in_item it;
        int gap;
        it.class_label    = cls;
        it.distance_value = dist_val;
        it.last_point     = last;
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        track_point(it);
        points_sent++;
        if (last) queries_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every vote is back and the back end is quiet.
    task automatic drain();
        push <= 1'b0;
        while (vote_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_k(input logic [knn_pkg::CFG_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        k_setting = value;
        cfg_writes++;
    endtask

    task automatic send_query(input int npts, input int dist_mode, input int cls_base,
                              input int cls_span);
        logic [knn_pkg::CLASS_W-1:0] cls;
        for (int i = 0; i < npts; i++) begin
            cls = knn_pkg::CLASS_W'((cls_base + $urandom_range(0, cls_span - 1)) %
                                    knn_pkg::NUM_CLASSES);
            send_point(cls, pick_distance(dist_mode), i == npts - 1);
        end
    endtask

    // k of one out of reset; the zero point must win over an all-ones one
    task automatic test_reset_k();
        send_point(4'd15, DIST_ALL_ONES, 1'b0);
        send_point(4'd0, '0, 1'b1);
    endtask

    task automatic test_k_zero();
        write_k(5'd0);
        send_point(4'd3, knn_pkg::DIST_W'(10), 1'b0);
        send_point(4'd7, knn_pkg::DIST_W'(10), 1'b1);
    endtask

    task automatic test_k_saturate();
        write_k(5'd31);
        send_point(4'd15, DIST_ALL_ONES, 1'b0);
        send_point(4'd15, knn_pkg::DIST_W'(2), 1'b0);
        send_point(4'd2, knn_pkg::DIST_W'(1), 1'b1);
    endtask

    task automatic test_vote_tie();
        write_k(5'd2);
        send_point(4'd9, knn_pkg::DIST_W'(4), 1'b0);
        send_point(4'd4, knn_pkg::DIST_W'(4), 1'b1);
    endtask

    // last point equals the largest kept distance of a full list: dropped
    task automatic test_full_list();
        write_k(5'd16);
        for (int i = 0; i < knn_pkg::MAX_NEIGHBORS - 1; i++) begin
            send_point(knn_pkg::CLASS_W'(i % 3), knn_pkg::DIST_W'(100 + i), 1'b0);
        end
        send_point(4'd12, DIST_ALL_ONES, 1'b0);
        send_point(4'd5, DIST_ALL_ONES, 1'b1);
    endtask

    task automatic test_random_queries();
        logic [knn_pkg::CFG_W-1:0] k_plan [8];
        int sent;
        int r;
        int npts;
        int span;
        k_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd0};
        k_plan[7] = knn_pkg::CFG_W'($urandom_range(0, 31));
        for (int ph = 0; ph < 8; ph++) begin
            write_k(k_plan[ph]);
            burst = (ph == 1 || ph == 4);
            sent = 0;
            while (sent < PHASE_POINTS) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    npts = $urandom_range(1, 8);
                end else if (r < 95) begin
                    npts = $urandom_range(9, 20);
                end else begin
                    npts = $urandom_range(21, 40);
                end
                span = ($urandom_range(0, 1) != 0) ? 3 : knn_pkg::NUM_CLASSES;
                send_query(npts, $urandom_range(DIST_NARROW, DIST_WIDE),
                           $urandom_range(0, knn_pkg::NUM_CLASSES - 1), span);
                sent += npts;
                if ($urandom_range(0, 19) == 0) begin
                    drain();
                end
            end
        end
        burst = 1'b0;
    endtask

    // result side: check each popped beat, stall pop at random
    always @(posedge i_clk) begin
        knn_pkg::t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (vote_q.size() == 0) begin
                    report_mismatch("result beat with no vote pending, class", -1,
                                    int'(o_result.winning_class));
                end else begin
                    want = vote_q.pop_front();
                    if (o_result.winning_class !== want.winning_class)
                        report_mismatch("winning_class", int'(want.winning_class),
                                        int'(o_result.winning_class));
                    if (o_result.winning_votes !== want.winning_votes)
                        report_mismatch("winning_votes", int'(want.winning_votes),
                                        int'(o_result.winning_votes));
                    if (o_result.neighbors_used !== want.neighbors_used)
                        report_mismatch("neighbors_used", int'(want.neighbors_used),
                                        int'(o_result.neighbors_used));
                end
                pop_hold = pick_gap();
            end else if (pop_hold > 0) begin
                pop_hold--;
            end
            pop <= (pop_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d votes pending",
                     stall_cycles, vote_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        near_fill    = 0;
        k_setting    = knn_pkg::CFG_W'(1);
        errors       = 0;
        points_sent  = 0;
        queries_sent = 0;
        results_seen = 0;
        cfg_writes   = 0;
        stall_cycles = 0;
        pop_hold     = 0;
        burst        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_k();
        test_k_zero();
        test_k_saturate();
        test_vote_tie();
        test_full_list();
        test_random_queries();

        drain();
        $display("Sent %0d training points in %0d queries, %0d votes checked,",
                 points_sent, queries_sent, results_seen);
        $display("across %0d writes of k including 0, 16, 17 and 31", cfg_writes);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### knn_majority_classifier.f
rtl/knn_pkg.sv
rtl/knn_insert.sv
rtl/knn_job_fifo.sv
rtl/knn_vote.sv
rtl/knn_majority_classifier.sv
rtl/knn_chk.sv
tb/sv/knn_majority_classifier_tb.sv
